// ----- src/sync_length_checksum_deframer_core_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_CORE_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SLCD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Check that cond is never true.
`define SLCD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- src/slcd_pkg.sv -----
// Types, constants and helpers shared by the deframer modules.
`timescale 1ns / 1ps
package slcd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] CSUM_SEED   = 8'hFF;

  localparam int unsigned PAY_AW     = 6;            // data bytes per frame, log2
  localparam int unsigned BANK_AW    = 1;            // two payload banks
  localparam int unsigned MEM_AW     = PAY_AW + BANK_AW;
  localparam int unsigned MEM_DEPTH  = 1 << MEM_AW;
  localparam int unsigned IDX_W      = 7;            // frame byte index, up to 66
  localparam logic [IDX_W-1:0] HDR_BYTES = 7'd3;     // address, length, code
  localparam logic [IDX_W-1:0] OVERHEAD  = 7'd4;     // header plus checksum

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CSUM = 2'd1,
    ST_CODE = 2'd2
  } frame_status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } item_kind_e;

  // Frame descriptor handed from front to back.
  typedef struct packed {
    logic [7:0]         addr;
    logic [7:0]         len;
    logic [7:0]         code;
    frame_status_e      status;
    logic [BANK_AW-1:0] bank;
  } desc_t;

  // Payload memory write port.
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // Bank release from back to front.
  typedef struct packed {
    logic               valid;
    logic [BANK_AW-1:0] bank;
  } bank_rel_t;

  function automatic logic code_known(input logic [7:0] c);
    logic k;
    case (c)
      8'h21, 8'h24, 8'h25, 8'h26, 8'h2C, 8'h2D,
      8'h2F, 8'h30, 8'h33, 8'h34, 8'h36: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ----- src/slcd_rx_if.sv -----
// Received byte channel.
`timescale 1ns / 1ps
interface slcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/slcd_res_if.sv -----
// Result item channel.
`timescale 1ns / 1ps
interface slcd_res_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic [7:0] frame_address;
  logic [1:0] status_bits;
  logic [7:0] control_code;
  logic [5:0] payload_count;
  logic       last_of_run;

  modport source (
    output valid, input ready,
    output item_kind, output payload_byte, output frame_status, output frame_address,
    output status_bits, output control_code, output payload_count, output last_of_run
  );
  modport sink (
    input valid, output ready,
    input item_kind, input payload_byte, input frame_status, input frame_address,
    input status_bits, input control_code, input payload_count, input last_of_run
  );
endinterface

// ----- src/slcd_front.sv -----
// Front end: sync hunt, header capture, checksum and payload writes.
`timescale 1ns / 1ps
module slcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  slcd_rx_if.sink             rx_i,
  output slcd_pkg::mem_wr_t   wr_o,
  output logic                push_o,
  output slcd_pkg::desc_t     desc_o,
  input  slcd_pkg::bank_rel_t rel_i
);
  import slcd_pkg::*;

  logic [7:0]         prev_q, prev_d;
  logic               in_frame_q, in_frame_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   fbc_q, fbc_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         addr_q, addr_d;
  logic [7:0]         len_q, len_d;
  logic [7:0]         code_q, code_d;
  logic [BANK_AW-1:0] bank_q, bank_d;
  logic [1:0]         full_q, full_d;

  logic               accept;
  logic [IDX_W-1:0]   idx_nxt;
  logic               frame_end;
  frame_status_e      status;

  // Hold off frame bytes while the current bank is still being drained.
  assign rx_i.ready = !in_frame_q || !full_q[bank_q];
  assign accept     = rx_i.valid && rx_i.ready;
  assign idx_nxt    = idx_q + 7'd1;
  assign frame_end  = accept && in_frame_q && (idx_nxt == fbc_q);

  // Classify the frame on its checksum byte.
  always_comb begin
    if (rx_i.rx_byte != sum_q) begin
      status = ST_CSUM;
    end else if (!code_known(code_q)) begin
      status = ST_CODE;
    end else begin
      status = ST_OK;
    end
  end

  assign push_o        = frame_end;
  assign desc_o.addr   = addr_q;
  assign desc_o.len    = len_q;
  assign desc_o.code   = code_q;
  assign desc_o.status = status;
  assign desc_o.bank   = bank_q;

  // Data bytes go to the current bank; the checksum byte lands past the data.
  assign wr_o.en   = accept && in_frame_q && (idx_q >= HDR_BYTES);
  assign wr_o.addr = {bank_q, PAY_AW'(idx_q - HDR_BYTES)};
  assign wr_o.data = rx_i.rx_byte;

  // Advance the frame parser.
  always_comb begin
    prev_d     = prev_q;
    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    fbc_d      = fbc_q;
    sum_d      = sum_q;
    addr_d     = addr_q;
    len_d      = len_q;
    code_d     = code_q;
    bank_d     = bank_q;
    full_d     = full_q;
    if (rel_i.valid) begin
      full_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_i.rx_byte == SYNC_SECOND && prev_q == SYNC_FIRST) begin
          in_frame_d = 1'b1;
          idx_d      = '0;
          fbc_d      = '0;
          sum_d      = CSUM_SEED;
        end else begin
          prev_d = rx_i.rx_byte;
        end
      end else begin
        prev_d = '0;
        if (idx_q == 7'd0) begin
          addr_d = rx_i.rx_byte;
        end else if (idx_q == 7'd1) begin
          len_d = rx_i.rx_byte;
          fbc_d = IDX_W'(rx_i.rx_byte[PAY_AW-1:0]) + OVERHEAD;
        end else if (idx_q == 7'd2) begin
          code_d = rx_i.rx_byte;
        end
        idx_d = idx_nxt;
        if (frame_end) begin
          in_frame_d     = 1'b0;
          idx_d          = '0;
          fbc_d          = '0;
          full_d[bank_q] = 1'b1;
          bank_d         = ~bank_q;
        end else begin
          sum_d = sum_q + rx_i.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      fbc_q      <= '0;
      sum_q      <= '0;
      addr_q     <= '0;
      len_q      <= '0;
      code_q     <= '0;
      bank_q     <= '0;
      full_q     <= '0;
    end else begin
      prev_q     <= prev_d;
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
      fbc_q      <= fbc_d;
      sum_q      <= sum_d;
      addr_q     <= addr_d;
      len_q      <= len_d;
      code_q     <= code_d;
      bank_q     <= bank_d;
      full_q     <= full_d;
    end
  end

endmodule

// ----- src/slcd_fifo.sv -----
// Two-entry queue of frame descriptors between front and back.
`timescale 1ns / 1ps
`include "sync_length_checksum_deframer_core_macros.svh"
module slcd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slcd_pkg::desc_t desc_i,
  input  logic            pop_i,
  output logic            valid_o,
  output slcd_pkg::desc_t desc_o
);
  import slcd_pkg::*;

  desc_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign desc_o  = slot_q[rd_ptr_q];

  // Advance pointers and occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store descriptors.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  `SLCD_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !pop_i && count_q == 2'd2)
  `SLCD_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && count_q == 2'd0)
  `SLCD_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q != 2'd3)

endmodule

// ----- src/slcd_back.sv -----
// Back end: payload memory and result sequencing for one frame at a time.
`timescale 1ns / 1ps
`include "sync_length_checksum_deframer_core_macros.svh"
module slcd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slcd_pkg::mem_wr_t    wr_i,
  input  logic                 q_valid_i,
  input  slcd_pkg::desc_t      q_desc_i,
  output logic                 pop_o,
  output slcd_pkg::bank_rel_t  rel_o,
  slcd_res_if.source           res_o
);
  import slcd_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_READ = 4'b0010,
    B_DATA = 4'b0100,
    B_STAT = 4'b1000
  } back_state_e;

  back_state_e       state_q, state_d;
  desc_t             desc_q, desc_d;
  logic [PAY_AW-1:0] cnt_q, cnt_d;
  logic [7:0]        rdata_q;
  logic [7:0]        mem [MEM_DEPTH];
  logic [MEM_AW-1:0] raddr;
  logic              out_acc;
  logic [PAY_AW-1:0] count;

  assign count   = desc_q.len[PAY_AW-1:0];
  assign raddr   = {desc_q.bank, cnt_q};
  assign out_acc = res_o.valid && res_o.ready;
  assign pop_o   = (state_q == B_IDLE) && q_valid_i;

  // Free the bank once the status item leaves.
  assign rel_o.valid = (state_q == B_STAT) && out_acc;
  assign rel_o.bank  = desc_q.bank;

  // Payload memory: front writes, back reads one entry per data item.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (state_q == B_READ) begin
      rdata_q <= mem[raddr];
    end
  end

  // Sequence data items, then the status item.
  always_comb begin
    state_d = state_q;
    desc_d  = desc_q;
    cnt_d   = cnt_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          desc_d = q_desc_i;
          cnt_d  = '0;
          if (q_desc_i.status == ST_OK && q_desc_i.len[PAY_AW-1:0] != '0) begin
            state_d = B_READ;
          end else begin
            state_d = B_STAT;
          end
        end
      end
      B_READ: state_d = B_DATA;
      B_DATA: begin
        if (out_acc) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == count - 1'b1) begin
            state_d = B_STAT;
          end else begin
            state_d = B_READ;
          end
        end
      end
      B_STAT: begin
        if (out_acc) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  // Drive the result channel from registered state.
  assign res_o.valid         = (state_q == B_DATA) || (state_q == B_STAT);
  assign res_o.item_kind     = (state_q == B_STAT) ? KIND_STATUS : KIND_DATA;
  assign res_o.payload_byte  = (state_q == B_DATA) ? rdata_q : 8'd0;
  assign res_o.frame_status  = (state_q == B_STAT) ? desc_q.status : ST_OK;
  assign res_o.frame_address = desc_q.addr;
  assign res_o.status_bits   = desc_q.len[7:6];
  assign res_o.control_code  = desc_q.code;
  assign res_o.payload_count = count;
  assign res_o.last_of_run   = (state_q == B_STAT);

  `SLCD_ASSERT_IMP(a_data_only_ok, clk_i, rst_ni, state_q == B_DATA, desc_q.status == ST_OK)
  `SLCD_ASSERT_IMP(a_cnt_in_range, clk_i, rst_ni, state_q == B_DATA, cnt_q < count)
  `SLCD_ASSERT_IMP(a_pop_has_data, clk_i, rst_ni, pop_o, q_valid_i)

endmodule

// ----- src/sync_length_checksum_deframer_core.sv -----
// Top level of the sync/length/checksum frame receiver.
// Input: one byte per cycle; frame bytes stall only while both payload banks await drain.
// Results: the first result follows the checksum byte through the queue, the memory read and the
// output; frames with no data items skip the read. Each data item is read, then presented; the
// status item is presented directly, and the back end passes idle to pop the next descriptor.
// Reset: asynchronous, clears parser, queue and sequencer; payload memory is not cleared.
`timescale 1ns / 1ps
module sync_length_checksum_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcd_rx_if.sink     rx_i,
  slcd_res_if.source  res_o
);
  import slcd_pkg::*;

  mem_wr_t   wr;
  logic      push;
  desc_t     push_desc;
  logic      pop;
  logic      q_valid;
  desc_t     q_desc;
  bank_rel_t rel;

  slcd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .wr_o   (wr),
    .push_o (push),
    .desc_o (push_desc),
    .rel_i  (rel)
  );

  slcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (q_desc)
  );

  slcd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .q_valid_i (q_valid),
    .q_desc_i  (q_desc),
    .pop_o     (pop),
    .rel_o     (rel),
    .res_o     (res_o)
  );

endmodule
